// ===== src/hns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants of the heightmap normal shader: map geometry,
// transaction payloads, register indexes, modes and the stage-to-stage
// structs.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int MAP_WIDTH  = 512;
  localparam int MAP_HEIGHT = 512;

  // Height difference times scale: |(h_p - h_o) * k| < 2^24
  localparam int DIFF_W = 25;
  // Q1.15 normal component, range -32768 .. 32768
  localparam int NRM_W  = 17;

  localparam logic [15:0] UNIT_Z = 16'd65280;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_GREY   = 2'd1;
  localparam logic [1:0] MODE_POSTER = 2'd2;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_SCALE   = 3'd1,
    CFG_LIGHT_X = 3'd2,
    CFG_LIGHT_Y = 3'd3,
    CFG_LIGHT_Z = 3'd4
  } cfg_idx_t;

  localparam logic [1:0]         MODE_RST    = MODE_GREY;
  localparam logic [15:0]        SCALE_RST   = 16'd5120;
  localparam logic signed [15:0] LIGHT_X_RST = 16'sd6993;
  localparam logic signed [15:0] LIGHT_Y_RST = 16'sd13986;
  localparam logic signed [15:0] LIGHT_Z_RST = -16'sd4895;

  typedef struct packed {
    logic       func;
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] height;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Scaled height differences towards up, right, down and left
  typedef struct packed {
    logic                     valid;
    logic signed [DIFF_W-1:0] da;
    logic signed [DIFF_W-1:0] db;
    logic signed [DIFF_W-1:0] dc;
    logic signed [DIFF_W-1:0] dd;
  } hns_diff_t;

  typedef struct packed {
    logic                    valid;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } hns_nrm_t;

endpackage
`default_nettype wire

// ===== src/hns_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hns_frame_ram
// Single-port frame store of 8-bit heights, one access a cycle, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module hns_frame_ram (
  input  logic                                                 clk,
  input  logic                                                 we,
  input  logic [$clog2(hns_pkg::MAP_WIDTH*hns_pkg::MAP_HEIGHT)-1:0] addr,
  input  logic [7:0]                                           wdata,
  output logic [7:0]                                           rdata
);
  import hns_pkg::*;

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/hns_fetch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hns_fetch
// Frame store access sequencer: writes loads, reads the centre and its four
// wrapped neighbours for a shade transaction and forms the scaled height
// differences.
// ----------------------------------------------------------------------------
module hns_fetch (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  hns_pkg::in_item_t in_data,
  input  logic [15:0]       height_scale,
  output logic              busy,
  output hns_pkg::hns_diff_t diff
);
  import hns_pkg::*;

  localparam int COL_W  = $clog2(MAP_WIDTH);
  localparam int ROW_W  = $clog2(MAP_HEIGHT);
  localparam int ADDR_W = $clog2(MAP_WIDTH * MAP_HEIGHT);
  localparam int PRD_W  = 26;

  // The centre is read on the accept cycle and carries the S_IDLE tag
  typedef enum logic [2:0] {S_IDLE, S_UP, S_RIGHT, S_DOWN, S_LEFT} seq_t;

  seq_t             step_r, step_nxt;
  seq_t             rd_tag_r;
  logic             rd_vld_r;
  logic [COL_W-1:0] col_r, col_in, col_sel, col_p1, col_m1;
  logic [ROW_W-1:0] row_r, row_in, row_sel, row_p1, row_m1;
  logic             accept, shade_acc, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  logic [7:0]       h_o_r, h_u_r, h_r_r, h_d_r;
  logic signed [8:0]  dif_u, dif_r, dif_d, dif_l;
  logic signed [16:0] k_s;
  logic signed [PRD_W-1:0] p_u, p_r, p_d, p_l;
  hns_diff_t        diff_r;

  assign busy      = (step_r != S_IDLE);
  assign accept    = start && !busy;
  assign shade_acc = accept && (in_data.func == FUNC_SHADE);
  assign ram_we    = accept && (in_data.func == FUNC_LOAD);

  assign col_in = COL_W'(in_data.col % MAP_WIDTH);
  assign row_in = ROW_W'(in_data.row % MAP_HEIGHT);
  assign col_p1 = (col_r == COL_W'(MAP_WIDTH - 1))  ? '0 : col_r + 1'b1;
  assign col_m1 = (col_r == '0) ? COL_W'(MAP_WIDTH - 1)  : col_r - 1'b1;
  assign row_p1 = (row_r == ROW_W'(MAP_HEIGHT - 1)) ? '0 : row_r + 1'b1;
  assign row_m1 = (row_r == '0) ? ROW_W'(MAP_HEIGHT - 1) : row_r - 1'b1;

  always_comb begin
    unique case (step_r)
      S_UP: begin
        col_sel = col_r;
        row_sel = row_m1;
      end
      S_RIGHT: begin
        col_sel = col_p1;
        row_sel = row_r;
      end
      S_DOWN: begin
        col_sel = col_r;
        row_sel = row_p1;
      end
      S_LEFT: begin
        col_sel = col_m1;
        row_sel = row_r;
      end
      default: begin
        col_sel = col_in;
        row_sel = row_in;
      end
    endcase
  end

  assign ram_addr = ADDR_W'(row_sel) * ADDR_W'(MAP_WIDTH) + ADDR_W'(col_sel);

  hns_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.height),
    .rdata (ram_rdata)
  );

  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      S_IDLE:  if (shade_acc) step_nxt = S_UP;
      S_UP:    step_nxt = S_RIGHT;
      S_RIGHT: step_nxt = S_DOWN;
      S_DOWN:  step_nxt = S_LEFT;
      S_LEFT:  step_nxt = S_IDLE;
      default: step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= S_IDLE;
      rd_vld_r <= 1'b0;
      rd_tag_r <= S_IDLE;
    end else begin
      step_r   <= step_nxt;
      rd_vld_r <= shade_acc || busy;
      rd_tag_r <= step_r;
    end
  end

  // Hold the centre coordinate for the neighbour reads
  always_ff @(posedge clk) begin
    if (shade_acc) begin
      col_r <= col_in;
      row_r <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_tag_r)
        S_IDLE:  h_o_r <= ram_rdata;
        S_UP:    h_u_r <= ram_rdata;
        S_RIGHT: h_r_r <= ram_rdata;
        S_DOWN:  h_d_r <= ram_rdata;
        default: ;
      endcase
    end
  end

  assign k_s   = $signed({1'b0, height_scale});
  assign dif_u = $signed({1'b0, h_u_r}) - $signed({1'b0, h_o_r});
  assign dif_r = $signed({1'b0, h_r_r}) - $signed({1'b0, h_o_r});
  assign dif_d = $signed({1'b0, h_d_r}) - $signed({1'b0, h_o_r});
  assign dif_l = $signed({1'b0, ram_rdata}) - $signed({1'b0, h_o_r});
  assign p_u   = dif_u * k_s;
  assign p_r   = dif_r * k_s;
  assign p_d   = dif_d * k_s;
  assign p_l   = dif_l * k_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r.valid <= 1'b0;
    end else begin
      diff_r.valid <= rd_vld_r && (rd_tag_r == S_LEFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && (rd_tag_r == S_LEFT)) begin
      diff_r.da <= p_u[DIFF_W-1:0];
      diff_r.db <= p_r[DIFF_W-1:0];
      diff_r.dc <= p_d[DIFF_W-1:0];
      diff_r.dd <= p_l[DIFF_W-1:0];
    end
  end

  assign diff = diff_r;

`ifndef SYNTH
  a_shade_to_diff: assert property (@(posedge clk) disable iff (!rst_n)
    shade_acc |-> ##6 diff_r.valid)
    else $error("shade transaction did not yield differences after five reads");

  a_diff_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r.valid |=> !diff_r.valid)
    else $error("difference sets closer than one per shade transaction");

  a_centre_then_up: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && (rd_tag_r == S_IDLE)) |-> (step_r == S_UP))
    else $error("centre read not followed by the up neighbour read");
`endif

endmodule
`default_nettype wire

// ===== src/hns_normal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hns_normal
// Triangle normal pipeline: four triangles a pixel on consecutive cycles,
// squares, a bit-per-stage square root, three bit-per-stage dividers and a
// quarter-average accumulator.
// ----------------------------------------------------------------------------
module hns_normal (
  input  logic               clk,
  input  logic               rst_n,
  input  hns_pkg::hns_diff_t diff,
  output hns_pkg::hns_nrm_t  nrm
);
  import hns_pkg::*;

  localparam int MAG_W     = DIFF_W - 1;
  localparam int SQR_W     = 2 * MAG_W;
  // (2 * (2^24)^2 + 65280^2) << 12 stays below 2^62
  localparam int RAD_W     = 62;
  localparam int RAD_SH    = 12;
  localparam int SQ_STEPS  = RAD_W / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int FRAC_SH   = 21;
  localparam int DVD_W     = MAG_W + FRAC_SH + 2;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = QUO_W;
  localparam int CMP_W     = QUO_W + 1;
  localparam int ACC_W     = CMP_W + 2;
  localparam int LANES     = 3;
  localparam logic [SQR_W-1:0] UNIT_Z_SQ = SQR_W'(64'(UNIT_Z) * 64'(UNIT_Z));

  // Triangle order: up-right, right-down, down-left, left-up
  localparam logic [1:0] TRI_UR = 2'd0;
  localparam logic [1:0] TRI_RD = 2'd1;
  localparam logic [1:0] TRI_DL = 2'd2;
  localparam logic [1:0] TRI_LU = 2'd3;

  // Feeder
  logic signed [DIFF_W-1:0] da_r, db_r, dc_r, dd_r, tx, ty;
  logic                     feed_act_r;
  logic [1:0]               feed_idx_r;
  logic [MAG_W-1:0]         mx, my;

  // Triangle and square stages
  logic             t_vld_r, s_vld_r;
  logic [1:0]       t_idx_r, s_idx_r;
  logic             t_sx_r, t_sy_r, s_sx_r, s_sy_r;
  logic [MAG_W-1:0] t_mx_r, t_my_r, s_mx_r, s_my_r;
  logic [SQR_W-1:0] s_xx_r, s_yy_r;

  // Square root stages, entry 0 is the radicand register
  logic [RAD_W-1:0] sq_v_r   [SQ_STEPS+1];
  logic [RAD_W-1:0] sq_r_r   [SQ_STEPS+1];
  logic             sq_vld_r [SQ_STEPS+1];
  logic [1:0]       sq_idx_r [SQ_STEPS+1];
  logic             sq_sx_r  [SQ_STEPS+1];
  logic             sq_sy_r  [SQ_STEPS+1];
  logic [MAG_W-1:0] sq_mx_r  [SQ_STEPS+1];
  logic [MAG_W-1:0] sq_my_r  [SQ_STEPS+1];
  logic [ROOT_W-1:0] root;

  // Divider stages, entry 0 is the dividend register
  logic [DVD_W-1:0]  dv_rem_r [DIV_STEPS+1][LANES];
  logic [QUO_W-1:0]  dv_q_r   [DIV_STEPS+1][LANES];
  logic [ROOT_W-1:0] dv_d_r   [DIV_STEPS+1];
  logic              dv_vld_r [DIV_STEPS+1];
  logic [1:0]        dv_idx_r [DIV_STEPS+1];
  logic              dv_sx_r  [DIV_STEPS+1];
  logic              dv_sy_r  [DIV_STEPS+1];

  // Accumulator
  logic signed [CMP_W-1:0] cmp [LANES];
  logic signed [ACC_W-1:0] acc_r [LANES];
  logic signed [ACC_W-1:0] tot [LANES];
  logic signed [ACC_W-1:0] rnd [LANES];
  logic                    last_tri;
  hns_nrm_t                nrm_r;

  // Feeder: spread one difference set over the four triangles, on consecutive cycles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_act_r <= 1'b0;
      feed_idx_r <= TRI_UR;
    end else if (diff.valid) begin
      feed_act_r <= 1'b1;
      feed_idx_r <= TRI_UR;
    end else if (feed_act_r) begin
      feed_idx_r <= feed_idx_r + 1'b1;
      if (feed_idx_r == TRI_LU) begin
        feed_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (diff.valid) begin
      da_r <= diff.da;
      db_r <= diff.db;
      dc_r <= diff.dc;
      dd_r <= diff.dd;
    end
  end

  always_comb begin
    unique case (feed_idx_r)
      TRI_UR: begin
        tx = -db_r;
        ty = da_r;
      end
      TRI_RD: begin
        tx = -db_r;
        ty = -dc_r;
      end
      TRI_DL: begin
        tx = dd_r;
        ty = -dc_r;
      end
      TRI_LU: begin
        tx = dd_r;
        ty = da_r;
      end
    endcase
  end

  assign mx = tx[DIFF_W-1] ? MAG_W'(-tx) : MAG_W'(tx);
  assign my = ty[DIFF_W-1] ? MAG_W'(-ty) : MAG_W'(ty);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r        <= 1'b0;
      s_vld_r        <= 1'b0;
      sq_vld_r[0]    <= 1'b0;
    end else begin
      t_vld_r        <= feed_act_r;
      s_vld_r        <= t_vld_r;
      sq_vld_r[0]    <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t_idx_r <= feed_idx_r;
    t_sx_r  <= tx[DIFF_W-1];
    t_sy_r  <= ty[DIFF_W-1];
    t_mx_r  <= mx;
    t_my_r  <= my;

    s_idx_r <= t_idx_r;
    s_sx_r  <= t_sx_r;
    s_sy_r  <= t_sy_r;
    s_mx_r  <= t_mx_r;
    s_my_r  <= t_my_r;
    s_xx_r  <= SQR_W'(t_mx_r) * SQR_W'(t_mx_r);
    s_yy_r  <= SQR_W'(t_my_r) * SQR_W'(t_my_r);

    sq_v_r[0]   <= (RAD_W'(s_xx_r) + RAD_W'(s_yy_r) + RAD_W'(UNIT_Z_SQ)) << RAD_SH;
    sq_r_r[0]   <= '0;
    sq_idx_r[0] <= s_idx_r;
    sq_sx_r[0]  <= s_sx_r;
    sq_sy_r[0]  <= s_sy_r;
    sq_mx_r[0]  <= s_mx_r;
    sq_my_r[0]  <= s_my_r;
  end

  // One root bit a stage, trial bit 4^(SQ_STEPS-1) down to 1
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [RAD_W-1:0] TRIAL_BIT = RAD_W'(1) << (2 * (SQ_STEPS - 1 - i));
    logic [RAD_W-1:0] trial;
    logic             fits;

    assign trial = sq_r_r[i] + TRIAL_BIT;
    assign fits  = (sq_v_r[i] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sq_v_r[i+1]   <= fits ? sq_v_r[i] - trial : sq_v_r[i];
      sq_r_r[i+1]   <= fits ? (sq_r_r[i] >> 1) + TRIAL_BIT : sq_r_r[i] >> 1;
      sq_idx_r[i+1] <= sq_idx_r[i];
      sq_sx_r[i+1]  <= sq_sx_r[i];
      sq_sy_r[i+1]  <= sq_sy_r[i];
      sq_mx_r[i+1]  <= sq_mx_r[i];
      sq_my_r[i+1]  <= sq_my_r[i];
    end
  end

  assign root = sq_r_r[SQ_STEPS][ROOT_W-1:0];

  // Dividend with half the divisor added for round half up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0][0] <= (DVD_W'(sq_mx_r[SQ_STEPS]) << FRAC_SH) + DVD_W'(root >> 1);
    dv_rem_r[0][1] <= (DVD_W'(sq_my_r[SQ_STEPS]) << FRAC_SH) + DVD_W'(root >> 1);
    dv_rem_r[0][2] <= (DVD_W'(UNIT_Z) << FRAC_SH) + DVD_W'(root >> 1);
    for (int l = 0; l < LANES; l++) begin
      dv_q_r[0][l] <= '0;
    end
    dv_d_r[0]   <= root;
    dv_idx_r[0] <= sq_idx_r[SQ_STEPS];
    dv_sx_r[0]  <= sq_sx_r[SQ_STEPS];
    dv_sy_r[0]  <= sq_sy_r[SQ_STEPS];
  end

  // One quotient bit a stage, most significant first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = QUO_W - 1 - j;
    logic [DVD_W-1:0] den;

    assign den = DVD_W'(dv_d_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (dv_rem_r[j][l] >= den) begin
          dv_rem_r[j+1][l] <= dv_rem_r[j][l] - den;
          dv_q_r[j+1][l]   <= dv_q_r[j][l] | (QUO_W'(1) << SH);
        end else begin
          dv_rem_r[j+1][l] <= dv_rem_r[j][l];
          dv_q_r[j+1][l]   <= dv_q_r[j][l];
        end
      end
      dv_d_r[j+1]   <= dv_d_r[j];
      dv_idx_r[j+1] <= dv_idx_r[j];
      dv_sx_r[j+1]  <= dv_sx_r[j];
      dv_sy_r[j+1]  <= dv_sy_r[j];
    end
  end

  always_comb begin
    cmp[0] = dv_sx_r[DIV_STEPS] ? -$signed({1'b0, dv_q_r[DIV_STEPS][0]})
                                :  $signed({1'b0, dv_q_r[DIV_STEPS][0]});
    cmp[1] = dv_sy_r[DIV_STEPS] ? -$signed({1'b0, dv_q_r[DIV_STEPS][1]})
                                :  $signed({1'b0, dv_q_r[DIV_STEPS][1]});
    cmp[2] = $signed({1'b0, dv_q_r[DIV_STEPS][2]});
    for (int l = 0; l < LANES; l++) begin
      tot[l] = ((dv_idx_r[DIV_STEPS] == TRI_UR) ? ACC_W'(0) : acc_r[l]) + ACC_W'(cmp[l]);
      rnd[l] = (tot[l] + ACC_W'(2)) >>> 2;
    end
  end

  assign last_tri = dv_vld_r[DIV_STEPS] && (dv_idx_r[DIV_STEPS] == TRI_LU);

  always_ff @(posedge clk) begin
    if (dv_vld_r[DIV_STEPS]) begin
      for (int l = 0; l < LANES; l++) begin
        acc_r[l] <= tot[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r.valid <= 1'b0;
    end else begin
      nrm_r.valid <= last_tri;
    end
  end

  // Quarter of the sum, rounded half up
  always_ff @(posedge clk) begin
    if (last_tri) begin
      nrm_r.nx <= rnd[0][NRM_W-1:0];
      nrm_r.ny <= rnd[1][NRM_W-1:0];
      nrm_r.nz <= rnd[2][NRM_W-1:0];
    end
  end

  assign nrm = nrm_r;

endmodule
`default_nettype wire

// ===== src/hns_shade.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hns_shade
// Colour stage: normal map channels, lit grey shade or posterized shade,
// chosen by mode, into the result register.
// ----------------------------------------------------------------------------
module hns_shade (
  input  logic               clk,
  input  logic               rst_n,
  input  hns_pkg::hns_nrm_t  nrm,
  input  logic [1:0]         mode,
  input  logic signed [15:0] light_x,
  input  logic signed [15:0] light_y,
  input  logic signed [15:0] light_z,
  output logic               out_valid,
  output hns_pkg::out_item_t out_data
);
  import hns_pkg::*;

  localparam int PRD_W   = NRM_W + 16;
  localparam int SHD_W   = PRD_W + 2;
  localparam int SCL_W   = SHD_W + 8;
  localparam int CH_W    = NRM_W + 8;
  localparam int SHD_SH  = 29;
  localparam int POST_HI = 120;
  localparam int POST_LO = 70;
  localparam logic [7:0] LEVEL_HI  = 8'd128;
  localparam logic [7:0] LEVEL_MID = 8'd80;
  localparam logic [7:0] LEVEL_LO  = 8'd32;
  localparam logic signed [NRM_W:0] HALF = (NRM_W+1)'(32768);

  logic signed [PRD_W-1:0] px_r, py_r, pz_r;
  logic signed [SHD_W-1:0] s_r;
  logic [NRM_W-1:0]        off [3];
  logic [CH_W-1:0]         chs [3];
  logic [7:0]              ch1_r [3];
  logic [7:0]              ch2_r [3];
  logic                    v1_r, v2_r, out_valid_r;
  logic [SCL_W-1:0]        scl;
  logic [SCL_W-SHD_SH-1:0] br_w;
  logic [7:0]              br, post, grey;
  out_item_t               out_r;

  always_comb begin
    off[0] = NRM_W'(HALF - (NRM_W+1)'(nrm.nx));
    off[1] = NRM_W'(HALF - (NRM_W+1)'(nrm.ny));
    off[2] = NRM_W'(HALF - (NRM_W+1)'(nrm.nz));
    for (int c = 0; c < 3; c++) begin
      chs[c] = CH_W'(off[c]) * CH_W'(255);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= nrm.valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= nrm.nx * light_x;
    py_r <= nrm.ny * light_y;
    pz_r <= nrm.nz * light_z;
    for (int c = 0; c < 3; c++) begin
      ch1_r[c] <= chs[c][NRM_W+6 -: 8];
      ch2_r[c] <= ch1_r[c];
    end
    s_r <= SHD_W'(px_r) + SHD_W'(py_r) + SHD_W'(pz_r);
  end

  // Non-positive shade is black; clamp the scaled value at full white
  always_comb begin
    scl  = (SCL_W'(s_r) << 8) - SCL_W'(s_r);
    br_w = scl[SCL_W-1:SHD_SH];
    if (s_r <= 0) begin
      br = 8'd0;
    end else if (br_w > (SCL_W-SHD_SH)'(255)) begin
      br = 8'd255;
    end else begin
      br = br_w[7:0];
    end
    priority if (br > 8'(POST_HI)) begin
      post = LEVEL_HI;
    end else if (br > 8'(POST_LO)) begin
      post = LEVEL_MID;
    end else begin
      post = LEVEL_LO;
    end
    grey = br;
  end

  always_ff @(posedge clk) begin
    unique case (mode)
      MODE_NORMAL: begin
        out_r.red   <= ch2_r[0];
        out_r.green <= ch2_r[1];
        out_r.blue  <= ch2_r[2];
      end
      MODE_POSTER: begin
        out_r.red   <= post;
        out_r.green <= post;
        out_r.blue  <= post;
      end
      default: begin
        out_r.red   <= grey;
        out_r.green <= grey;
        out_r.blue  <= grey;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/heightmap_normal_shader.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_normal_shader
// Toroidal height frame store with a pipelined normal and hillshade path.
// ----------------------------------------------------------------------------
// A load transaction (func 0) writes one height without raising busy. A shade
// transaction (func 1) makes five reads of the single-port frame store, one
// each for the pixel and its up, right, down and left neighbours, and holds
// busy high from the up read to the left read; that store port sets the rate.
// Behind it the normal, square root, divider and colour stages are fully
// pipelined, so a new shade transaction can be taken while earlier ones are
// still in flight, and each leaves as a one-cycle out_valid strobe that cannot
// be held off. Reads of heights never loaded give undefined pixels. Write
// configuration only while no shade result is outstanding.
// ----------------------------------------------------------------------------
module heightmap_normal_shader (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hns_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output hns_pkg::out_item_t out_data
);
  import hns_pkg::*;

  logic [1:0]         mode_r;
  logic [15:0]        scale_r;
  logic signed [15:0] light_x_r, light_y_r, light_z_r;
  hns_diff_t          diff;
  hns_nrm_t           nrm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RST;
      scale_r   <= SCALE_RST;
      light_x_r <= LIGHT_X_RST;
      light_y_r <= LIGHT_Y_RST;
      light_z_r <= LIGHT_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_wdata[1:0];
        CFG_SCALE:   scale_r   <= cfg_wdata;
        CFG_LIGHT_X: light_x_r <= cfg_wdata;
        CFG_LIGHT_Y: light_y_r <= cfg_wdata;
        CFG_LIGHT_Z: light_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hns_fetch u_fetch (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_data      (in_data),
    .height_scale (scale_r),
    .busy         (busy),
    .diff         (diff)
  );

  hns_normal u_normal (
    .clk   (clk),
    .rst_n (rst_n),
    .diff  (diff),
    .nrm   (nrm)
  );

  hns_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .nrm       (nrm),
    .mode      (mode_r),
    .light_x   (light_x_r),
    .light_y   (light_y_r),
    .light_z   (light_z_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
